// ===== rtl/pvs_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pvs_pkg
// Shared types, constants and helpers for the polar velocity smoother.
// ----------------------------------------------------------------------------
package pvs_pkg;

    localparam int CORDIC_STEPS = 20;
    localparam int ISQRT_STEPS  = 16;

    // 1/K of the 20-step CORDIC, Q1.30
    localparam logic signed [33:0] CORDIC_INV_GAIN = 34'sd652032874;

    localparam logic [16:0] WEIGHT_ONE = 17'd65536;

    localparam logic [16:0] SPEED_ALPHA_RST   = 17'd16384;
    localparam logic [16:0] HEADING_ALPHA_RST = 17'd16384;
    localparam logic [14:0] SNAP_TOL_RST      = 15'd0;
    localparam logic [15:0] DEADZONE_RST      = 16'd1638;

    localparam logic [7:0] CFG_SPEED_ALPHA   = 8'd0;
    localparam logic [7:0] CFG_HEADING_ALPHA = 8'd1;
    localparam logic [7:0] CFG_SNAP_TOL      = 8'd2;
    localparam logic [7:0] CFG_DEADZONE      = 8'd3;

    localparam logic signed [51:0] ROUND_Q30 = 52'sd536870912;
    localparam logic signed [51:0] ROUND_Q16 = 52'sd32768;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MAG_X,
        ST_MAG_Y,
        ST_DZ,
        ST_VEC,
        ST_TGT,
        ST_ROT1,
        ST_SCALE,
        ST_HSTEP,
        ST_SPD0,
        ST_SPD1,
        ST_ROT2,
        ST_OUTX,
        ST_OUTY,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic load_vec;
        logic load_rot;
        logic step;
    } cordic_ctl_t;

    function automatic logic [31:0] atan_at(input logic [4:0] i);
        logic [31:0] v;
        case (i)
            5'd0:    v = 32'd536870912;
            5'd1:    v = 32'd316933406;
            5'd2:    v = 32'd167458907;
            5'd3:    v = 32'd85004756;
            5'd4:    v = 32'd42667331;
            5'd5:    v = 32'd21354465;
            5'd6:    v = 32'd10679838;
            5'd7:    v = 32'd5340245;
            5'd8:    v = 32'd2670163;
            5'd9:    v = 32'd1335087;
            5'd10:   v = 32'd667544;
            5'd11:   v = 32'd333772;
            5'd12:   v = 32'd166886;
            5'd13:   v = 32'd83443;
            5'd14:   v = 32'd41722;
            5'd15:   v = 32'd20861;
            5'd16:   v = 32'd10430;
            5'd17:   v = 32'd5215;
            5'd18:   v = 32'd2608;
            5'd19:   v = 32'd1304;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

    function automatic logic signed [16:0] sat17(input logic signed [51:0] v);
        logic signed [16:0] r;
        if (v > 52'sd65535) begin
            r = 17'sd65535;
        end else if (v < -52'sd65536) begin
            r = -17'sd65536;
        end else begin
            r = v[16:0];
        end
        return r;
    endfunction

endpackage

// ===== rtl/pvs_cordic.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pvs_cordic
// Shared CORDIC engine, one micro-rotation per step: vectoring (atan2) or
// rotation (cos/sin of a 16-bit angle with quadrant fold).
// ----------------------------------------------------------------------------
module pvs_cordic (
    input  logic                aclk,
    input  pvs_pkg::cordic_ctl_t ctl,
    input  logic signed [15:0]  vel_x,
    input  logic signed [15:0]  vel_y,
    input  logic [15:0]         angle,
    input  logic [4:0]          iter,
    output logic signed [33:0]  cos_out,
    output logic signed [33:0]  sin_out,
    output logic [31:0]         angle_out
);

    logic signed [33:0] x_reg, x_next;
    logic signed [33:0] y_reg, y_next;
    logic signed [33:0] z_reg, z_next;
    logic               vec_reg, vec_next;
    logic               flip_reg, flip_next;

    logic signed [33:0] dx, dy, atn, vx_e, vy_e, zi;
    logic               up;

    always_comb begin
        dx   = x_reg >>> iter;
        dy   = y_reg >>> iter;
        atn  = 34'($unsigned(pvs_pkg::atan_at(iter)));
        up   = vec_reg ? (y_reg <= 34'sd0) : (z_reg >= 34'sd0);
        vx_e = 34'(vel_x);
        vy_e = 34'(vel_y);
        zi   = {{2{angle[15]}}, angle, 16'd0};

        x_next    = x_reg;
        y_next    = y_reg;
        z_next    = z_reg;
        vec_next  = vec_reg;
        flip_next = flip_reg;

        if (ctl.load_vec) begin
            vec_next  = 1'b1;
            flip_next = 1'b0;
            if (vel_x < 16'sd0) begin
                x_next = (-vx_e) <<< 14;
                y_next = (-vy_e) <<< 14;
                z_next = 34'sh0_8000_0000;
            end else begin
                x_next = vx_e <<< 14;
                y_next = vy_e <<< 14;
                z_next = 34'sd0;
            end
        end else if (ctl.load_rot) begin
            vec_next = 1'b0;
            x_next   = pvs_pkg::CORDIC_INV_GAIN;
            y_next   = 34'sd0;
            // fold back half of the circle into +-90 degrees
            if (zi > 34'sd1073741824) begin
                z_next    = zi - 34'sd2147483648;
                flip_next = 1'b1;
            end else if (zi < -34'sd1073741824) begin
                z_next    = zi + 34'sd2147483648;
                flip_next = 1'b1;
            end else begin
                z_next    = zi;
                flip_next = 1'b0;
            end
        end else if (ctl.step) begin
            if (up) begin
                x_next = x_reg - dy;
                y_next = y_reg + dx;
                z_next = z_reg - atn;
            end else begin
                x_next = x_reg + dy;
                y_next = y_reg - dx;
                z_next = z_reg + atn;
            end
        end
    end

    always_ff @(posedge aclk) begin
        x_reg    <= x_next;
        y_reg    <= y_next;
        z_reg    <= z_next;
        vec_reg  <= vec_next;
        flip_reg <= flip_next;
    end

    assign cos_out   = flip_reg ? -x_reg : x_reg;
    assign sin_out   = flip_reg ? -y_reg : y_reg;
    assign angle_out = z_reg[31:0];

endmodule

// ===== rtl/polar_velocity_smoother.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// polar_velocity_smoother
// Polar-form smoothing of a joystick velocity vector.
// ----------------------------------------------------------------------------
// Input stream s_*: one item per velocity sample, s_tdata = {vel_y, vel_x}.
// Output stream m_*: one item per input, m_tdata = {smooth_y, smooth_x}.
// Config channel cfg_*: always ready; index 0 speed_alpha, 1 heading_alpha,
// 2 snap_tolerance, 3 deadzone; other indexes are dropped. Write only while
// the block is idle.
// One item at a time: s_tready is high only in idle. A deadzone sample skips
// the atan2 pass; a heading jump of more than 90 degrees adds a pass for the
// cos of the jump. The latency is set by the passes of the shared CORDIC
// engine (atan2, optional cos of the jump, sin/cos of the heading); the square
// root runs beside the atan2 pass. A single 34x18 multiplier serves every
// product, one per cycle.
// The result stays in the output register until m_tready; the next item is
// taken the cycle after. Reset (aresetn low, synchronous) clears speed and
// heading and loads the register defaults.
// ----------------------------------------------------------------------------
module polar_velocity_smoother (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [15:0] vel_x, [31:16] vel_y
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [16:0] smooth_x, [33:17] smooth_y, zero pad
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_index,
    input  logic [16:0] cfg_data
);

    pvs_pkg::state_t state_reg, state_next;

    logic [16:0] speed_alpha_reg, heading_alpha_reg;
    logic [14:0] snap_tol_reg;
    logic [15:0] deadzone_reg;

    logic signed [15:0] vx_reg, vx_next, vy_reg, vy_next;
    logic signed [51:0] acc_reg, acc_next;
    logic               active_reg, active_next;
    logic [32:0]        sq_s_reg, sq_s_next, sq_r_reg, sq_r_next;
    logic [16:0]        target_reg, target_next;
    logic [15:0]        t_reg, t_next;
    logic signed [15:0] d_reg, d_next;
    logic signed [16:0] speed_reg, speed_next;
    logic [15:0]        heading_reg, heading_next;
    logic signed [16:0] outx_reg, outx_next, outy_reg, outy_next;
    logic [4:0]         it_reg, it_next;

    logic signed [33:0] mul_a;
    logic signed [17:0] mul_b;
    logic signed [51:0] prod;

    pvs_pkg::cordic_ctl_t cctl;
    logic [15:0]          c_angle;
    logic signed [33:0]   c_cos, c_sin;
    logic [31:0]          c_ang;

    logic [16:0]        aspd, ahdg;
    logic [31:0]        ang_rnd;
    logic [15:0]        t_raw, card, t_sel;
    logic signed [15:0] diff, d_cmb;
    logic [16:0]        adiff;
    logic               big;
    logic [32:0]        sq_bit, sq_trial;
    logic signed [51:0] hstep, spd_sum;
    logic               last_it;

    pvs_cordic u_cordic (
        .aclk      (aclk),
        .ctl       (cctl),
        .vel_x     (vx_reg),
        .vel_y     (vy_reg),
        .angle     (c_angle),
        .iter      (it_reg),
        .cos_out   (c_cos),
        .sin_out   (c_sin),
        .angle_out (c_ang)
    );

    assign aspd    = (speed_alpha_reg > pvs_pkg::WEIGHT_ONE) ?
                     pvs_pkg::WEIGHT_ONE : speed_alpha_reg;
    assign ahdg    = (heading_alpha_reg > pvs_pkg::WEIGHT_ONE) ?
                     pvs_pkg::WEIGHT_ONE : heading_alpha_reg;
    assign last_it = (it_reg == 5'(pvs_pkg::CORDIC_STEPS - 1));

    // target heading: round atan2, then cardinal snap; a deadzone sample keeps the current heading
    always_comb begin
        ang_rnd = c_ang + 32'h0000_8000;
        t_raw   = ang_rnd[31:16];
        card    = (t_raw + 16'd8192) & 16'hC000;
        diff    = $signed(t_raw - card);
        adiff   = diff[15] ? (17'd0 - 17'(diff)) : 17'(diff);
        t_sel   = t_raw;
        if (snap_tol_reg != 15'd0 && adiff <= {2'b00, snap_tol_reg}) begin
            t_sel = card;
        end
        if (!active_reg) begin
            t_sel = heading_reg;
        end
        d_cmb = $signed(t_sel - heading_reg);
        big   = (d_cmb > 16'sd16384) || (d_cmb < -16'sd16384);
    end

    // shared multiplier operand select
    always_comb begin
        mul_a = 34'sd0;
        mul_b = 18'sd0;
        case (state_reg)
            pvs_pkg::ST_MAG_X: begin
                mul_a = 34'(vx_reg);
                mul_b = 18'(vx_reg);
            end
            pvs_pkg::ST_MAG_Y: begin
                mul_a = 34'(vy_reg);
                mul_b = 18'(vy_reg);
            end
            pvs_pkg::ST_DZ: begin
                mul_a = $signed({18'd0, deadzone_reg});
                mul_b = $signed({2'd0, deadzone_reg});
            end
            pvs_pkg::ST_SCALE: begin
                mul_a = c_cos;
                mul_b = 18'(speed_reg);
            end
            pvs_pkg::ST_HSTEP: begin
                mul_a = 34'(d_reg);
                mul_b = $signed({1'b0, ahdg});
            end
            pvs_pkg::ST_SPD0: begin
                mul_a = 34'(speed_reg);
                mul_b = $signed({1'b0, pvs_pkg::WEIGHT_ONE - aspd});
            end
            pvs_pkg::ST_SPD1: begin
                mul_a = $signed({17'd0, target_reg});
                mul_b = $signed({1'b0, aspd});
            end
            pvs_pkg::ST_OUTX: begin
                mul_a = c_cos;
                mul_b = 18'(speed_reg);
            end
            pvs_pkg::ST_OUTY: begin
                mul_a = c_sin;
                mul_b = 18'(speed_reg);
            end
            default: begin
                mul_a = 34'sd0;
                mul_b = 18'sd0;
            end
        endcase
    end

    assign prod = 52'(mul_a) * 52'(mul_b);

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            pvs_pkg::ST_IDLE:  if (s_tvalid) state_next = pvs_pkg::ST_MAG_X;
            pvs_pkg::ST_MAG_X: state_next = pvs_pkg::ST_MAG_Y;
            pvs_pkg::ST_MAG_Y: state_next = pvs_pkg::ST_DZ;
            pvs_pkg::ST_DZ: begin
                state_next = (acc_reg > prod) ? pvs_pkg::ST_VEC : pvs_pkg::ST_TGT;
            end
            pvs_pkg::ST_VEC:   if (last_it) state_next = pvs_pkg::ST_TGT;
            pvs_pkg::ST_TGT: begin
                state_next = big ? pvs_pkg::ST_ROT1 : pvs_pkg::ST_HSTEP;
            end
            pvs_pkg::ST_ROT1:  if (last_it) state_next = pvs_pkg::ST_SCALE;
            pvs_pkg::ST_SCALE: state_next = pvs_pkg::ST_SPD0;
            pvs_pkg::ST_HSTEP: state_next = pvs_pkg::ST_SPD0;
            pvs_pkg::ST_SPD0:  state_next = pvs_pkg::ST_SPD1;
            pvs_pkg::ST_SPD1:  state_next = pvs_pkg::ST_ROT2;
            pvs_pkg::ST_ROT2:  if (last_it) state_next = pvs_pkg::ST_OUTX;
            pvs_pkg::ST_OUTX:  state_next = pvs_pkg::ST_OUTY;
            pvs_pkg::ST_OUTY:  state_next = pvs_pkg::ST_OUT;
            pvs_pkg::ST_OUT:   if (m_tready) state_next = pvs_pkg::ST_IDLE;
            default:           state_next = pvs_pkg::ST_IDLE;
        endcase
    end

    // handshake and CORDIC control
    always_comb begin
        s_tready      = (state_reg == pvs_pkg::ST_IDLE);
        m_tvalid      = (state_reg == pvs_pkg::ST_OUT);
        cctl.load_vec = (state_reg == pvs_pkg::ST_DZ);
        cctl.load_rot = (state_reg == pvs_pkg::ST_TGT) || (state_reg == pvs_pkg::ST_SPD1);
        cctl.step     = (state_reg == pvs_pkg::ST_VEC) || (state_reg == pvs_pkg::ST_ROT1) ||
                        (state_reg == pvs_pkg::ST_ROT2);
        c_angle       = (state_reg == pvs_pkg::ST_TGT) ? d_cmb : heading_next;
    end

    assign cfg_ready = 1'b1;
    assign m_tdata   = {6'd0, outy_reg, outx_reg};

    // datapath
    always_comb begin
        vx_next      = vx_reg;
        vy_next      = vy_reg;
        acc_next     = acc_reg;
        active_next  = active_reg;
        sq_s_next    = sq_s_reg;
        sq_r_next    = sq_r_reg;
        target_next  = target_reg;
        t_next       = t_reg;
        d_next       = d_reg;
        speed_next   = speed_reg;
        heading_next = heading_reg;
        outx_next    = outx_reg;
        outy_next    = outy_reg;
        it_next      = it_reg;

        sq_bit   = 33'h0_4000_0000 >> {it_reg[3:0], 1'b0};
        sq_trial = sq_r_reg + sq_bit;
        hstep    = (prod + pvs_pkg::ROUND_Q16) >>> 16;
        spd_sum  = (acc_reg + prod + pvs_pkg::ROUND_Q16) >>> 16;

        case (state_reg)
            pvs_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    vx_next = $signed(s_tdata[15:0]);
                    vy_next = $signed(s_tdata[31:16]);
                end
            end
            pvs_pkg::ST_MAG_X: acc_next = prod;
            pvs_pkg::ST_MAG_Y: acc_next = acc_reg + prod;
            pvs_pkg::ST_DZ: begin
                active_next = (acc_reg > prod);
                sq_s_next   = acc_reg[32:0];
                sq_r_next   = 33'd0;
                it_next     = 5'd0;
            end
            pvs_pkg::ST_VEC: begin
                // integer square root, one result bit per cycle
                if (it_reg < 5'(pvs_pkg::ISQRT_STEPS)) begin
                    if (sq_s_reg >= sq_trial) begin
                        sq_s_next = sq_s_reg - sq_trial;
                        sq_r_next = (sq_r_reg >> 1) + sq_bit;
                    end else begin
                        sq_r_next = sq_r_reg >> 1;
                    end
                end
                it_next = it_reg + 5'd1;
            end
            pvs_pkg::ST_TGT: begin
                target_next = active_reg ?
                              (17'(sq_r_reg) + 17'(sq_s_reg > sq_r_reg)) : 17'd0;
                t_next      = t_sel;
                d_next      = d_cmb;
                it_next     = 5'd0;
            end
            pvs_pkg::ST_ROT1: it_next = it_reg + 5'd1;
            pvs_pkg::ST_SCALE: begin
                speed_next   = pvs_pkg::sat17((prod + pvs_pkg::ROUND_Q30) >>> 30);
                heading_next = t_reg;
            end
            pvs_pkg::ST_HSTEP: heading_next = heading_reg + hstep[15:0];
            pvs_pkg::ST_SPD0:  acc_next = prod;
            pvs_pkg::ST_SPD1: begin
                speed_next = pvs_pkg::sat17(spd_sum);
                it_next    = 5'd0;
            end
            pvs_pkg::ST_ROT2: it_next = it_reg + 5'd1;
            pvs_pkg::ST_OUTX: outx_next = pvs_pkg::sat17((prod + pvs_pkg::ROUND_Q30) >>> 30);
            pvs_pkg::ST_OUTY: outy_next = pvs_pkg::sat17((prod + pvs_pkg::ROUND_Q30) >>> 30);
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg         <= pvs_pkg::ST_IDLE;
            speed_reg         <= 17'sd0;
            heading_reg       <= 16'd0;
            speed_alpha_reg   <= pvs_pkg::SPEED_ALPHA_RST;
            heading_alpha_reg <= pvs_pkg::HEADING_ALPHA_RST;
            snap_tol_reg      <= pvs_pkg::SNAP_TOL_RST;
            deadzone_reg      <= pvs_pkg::DEADZONE_RST;
        end else begin
            state_reg   <= state_next;
            speed_reg   <= speed_next;
            heading_reg <= heading_next;
            if (cfg_valid) begin
                case (cfg_index)
                    pvs_pkg::CFG_SPEED_ALPHA:   speed_alpha_reg   <= cfg_data;
                    pvs_pkg::CFG_HEADING_ALPHA: heading_alpha_reg <= cfg_data;
                    pvs_pkg::CFG_SNAP_TOL:      snap_tol_reg      <= cfg_data[14:0];
                    pvs_pkg::CFG_DEADZONE:      deadzone_reg      <= cfg_data[15:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        vx_reg     <= vx_next;
        vy_reg     <= vy_next;
        acc_reg    <= acc_next;
        active_reg <= active_next;
        sq_s_reg   <= sq_s_next;
        sq_r_reg   <= sq_r_next;
        target_reg <= target_next;
        t_reg      <= t_next;
        d_reg      <= d_next;
        outx_reg   <= outx_next;
        outy_reg   <= outy_next;
        it_reg     <= it_next;
    end

endmodule

// ===== rtl/pvs_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pvs_checker
// Port-level checks for the polar velocity smoother, bound to the top level.
// ----------------------------------------------------------------------------
module pvs_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [39:0] m_tdata
);

    // after reset the block is idle with nothing pending
    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> s_tready && !m_tvalid)
        else $error("not idle after reset");

    // an accepted item closes the input, and no result is valid right after the accept
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready && !m_tvalid)
        else $error("input open right after accept");

    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !s_tready)
        else $error("input open while result pending");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

endmodule

bind polar_velocity_smoother pvs_checker u_pvs_checker (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
);
